// ===== design/hse3d_pkg.sv =====
// Shared types and constants for the 3D seven-point heat stencil block.
// No dependencies; every other design file imports this package.
package hse3d_pkg;

    // Fixed field widths
    localparam int DATA_W = 32;
    localparam int COEF_W = 16;
    localparam int SIZE_W = 7;
    localparam int CIDX_W = 3;
    // Second difference, scaled term and final sum widths
    localparam int LAP_W  = 34;
    localparam int PROD_W = LAP_W + COEF_W + 1;
    localparam int TERM_W = PROD_W - 16;
    localparam int SUM_W  = TERM_W + 2;
    // Output queue depth and its pointer width
    localparam int OQ_DEPTH = 8;
    localparam int OQ_AW    = 3;

    // Configuration register indexes
    typedef enum logic [CIDX_W-1:0] {
        CFG_SIZE_X = 3'd0,
        CFG_SIZE_Y = 3'd1,
        CFG_SIZE_Z = 3'd2,
        CFG_COEF_X = 3'd3,
        CFG_COEF_Y = 3'd4,
        CFG_COEF_Z = 3'd5
    } t_cfg_idx;

    // Per-word control that follows the read data down the pipeline
    typedef struct packed {
        logic sample;
        logic emit;
        logic interior;
        logic last;
    } t_meta;

    // Sign-extend a sample to the second difference width
    function automatic logic signed [LAP_W-1:0] f_ext_lap(input logic signed [DATA_W-1:0] v);
        return LAP_W'(v);
    endfunction

endpackage

// ===== design/hse3d_window.sv =====
// Sample window: two identical circular memories, each with one write and two reads.
// Depends on hse3d_pkg for the data width.
module hse3d_window import hse3d_pkg::*; #(
    parameter int DEPTH = 8193,
    parameter int AW    = 14
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [AW-1:0]     i_ra0,
    input  logic [AW-1:0]     i_ra1,
    input  logic [AW-1:0]     i_rb0,
    input  logic [AW-1:0]     i_rb1,
    output logic [DATA_W-1:0] o_qa0,
    output logic [DATA_W-1:0] o_qa1,
    output logic [DATA_W-1:0] o_qb0,
    output logic [DATA_W-1:0] o_qb1
);

    logic [DATA_W-1:0] mem_a [DEPTH];
    logic [DATA_W-1:0] mem_b [DEPTH];

    // Both copies take every sample so that four neighbors can be read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem_a[i_waddr] <= i_wdata;
            mem_b[i_waddr] <= i_wdata;
        end
        o_qa0 <= mem_a[i_ra0];
        o_qa1 <= mem_a[i_ra1];
        o_qb0 <= mem_b[i_rb0];
        o_qb1 <= mem_b[i_rb1];
    end

endmodule

// ===== design/hse3d_datapath.sv =====
// Stencil arithmetic: second differences, coefficient products and saturating sum.
// Depends on hse3d_pkg; fed by the window read data and the top-level control.
module hse3d_datapath import hse3d_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_v1,
    input  t_meta             i_meta,
    input  logic [DATA_W-1:0] i_xp,
    input  logic [DATA_W-1:0] i_qa0,
    input  logic [DATA_W-1:0] i_qa1,
    input  logic [DATA_W-1:0] i_qb0,
    input  logic [DATA_W-1:0] i_qb1,
    input  logic [COEF_W-1:0] i_coef_x,
    input  logic [COEF_W-1:0] i_coef_y,
    input  logic [COEF_W-1:0] i_coef_z,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_updated,
    output logic              o_last,
    output logic [1:0]        o_inflight
);

    // Center and minus-z values trail the plus-z read by one and two samples.
    logic [DATA_W-1:0] r_p1, r_p0;

    logic signed [DATA_W-1:0] u1;
    logic signed [LAP_W-1:0]  two_u, lap_x, lap_y, lap_z;

    logic                     r_v2, r_int2, r_last2;
    logic signed [DATA_W-1:0] r_u2;
    logic signed [LAP_W-1:0]  r_lap_x, r_lap_y, r_lap_z;

    logic signed [PROD_W-1:0] prod_x, prod_y, prod_z;

    logic                     r_v3, r_int3, r_last3;
    logic signed [DATA_W-1:0] r_u3;
    logic signed [TERM_W-1:0] r_t_x, r_t_y, r_t_z;

    logic signed [SUM_W-1:0]  sum;

    // First stage: pick the center and form the three second differences.
    always_comb begin
        u1    = i_meta.sample ? $signed(r_p1) : $signed(i_qa0);
        two_u = f_ext_lap(u1) <<< 1;
        lap_z = f_ext_lap($signed(i_qa0)) + f_ext_lap($signed(r_p0)) - two_u;
        lap_y = f_ext_lap($signed(i_qb0)) + f_ext_lap($signed(i_qb1)) - two_u;
        lap_x = f_ext_lap($signed(i_xp)) + f_ext_lap($signed(i_qa1)) - two_u;
    end

    always_ff @(posedge i_clk) begin
        if (i_v1 && i_meta.sample) begin
            r_p1 <= i_qa0;
            r_p0 <= r_p1;
        end
        r_u2    <= u1;
        r_lap_x <= lap_x;
        r_lap_y <= lap_y;
        r_lap_z <= lap_z;
        r_int2  <= i_meta.interior;
        r_last2 <= i_meta.last;
    end

    // Second stage: scale by the coefficients, floor shift by 16.
    always_comb begin
        prod_x = PROD_W'(r_lap_x) * PROD_W'($signed({1'b0, i_coef_x}));
        prod_y = PROD_W'(r_lap_y) * PROD_W'($signed({1'b0, i_coef_y}));
        prod_z = PROD_W'(r_lap_z) * PROD_W'($signed({1'b0, i_coef_z}));
    end

    always_ff @(posedge i_clk) begin
        r_u3    <= r_u2;
        r_t_x   <= prod_x[PROD_W-1:16];
        r_t_y   <= prod_y[PROD_W-1:16];
        r_t_z   <= prod_z[PROD_W-1:16];
        r_int3  <= r_int2;
        r_last3 <= r_last2;
    end

    // Valid flags of the two arithmetic stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v2 <= i_v1 && i_meta.emit;
            r_v3 <= r_v2;
        end
    end

    // Final stage: add and saturate; faces of the grid keep their value.
    always_comb begin
        sum = SUM_W'(r_u3) + SUM_W'(r_t_x) + SUM_W'(r_t_y) + SUM_W'(r_t_z);
        if (!r_int3) begin
            o_updated = r_u3;
        end else if (sum[SUM_W-1:DATA_W-1] == '0 || sum[SUM_W-1:DATA_W-1] == '1) begin
            o_updated = sum[DATA_W-1:0];
        end else if (sum[SUM_W-1]) begin
            o_updated = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            o_updated = {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

    assign o_valid    = r_v3;
    assign o_last     = r_last3;
    assign o_inflight = {1'b0, r_v2} + {1'b0, r_v3};

endmodule

// ===== design/hse3d_outq.sv =====
// Output queue that holds finished words until the downstream side takes them.
// Depends on hse3d_pkg for depth and widths.
module hse3d_outq import hse3d_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    input  logic              i_last,
    input  logic              i_tready,
    output logic              o_tvalid,
    output logic [DATA_W-1:0] o_tdata,
    output logic              o_tlast,
    output logic [OQ_AW:0]    o_count
);

    logic [DATA_W:0]  r_q [OQ_DEPTH];
    logic [OQ_AW-1:0] r_wr, r_rd;
    logic [OQ_AW:0]   r_count;
    logic             pop;

    assign pop = o_tvalid && i_tready;

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr] <= {i_last, i_data};
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= r_count + {{OQ_AW{1'b0}}, i_push} - {{OQ_AW{1'b0}}, pop};
        end
    end

    assign o_tvalid = r_count != '0;
    assign o_tdata  = r_q[r_rd][DATA_W-1:0];
    assign o_tlast  = r_q[r_rd][DATA_W];
    assign o_count  = r_count;

endmodule

// ===== design/heat_stencil_3d_euler_top.sv =====
// Top level of the 3D seven-point heat stencil: configuration, grid position control,
// window addressing and credit flow. Depends on hse3d_pkg, window, datapath and outq.
//
//  Channel     Direction  Contents
//  s_axis      in         tdata[31:0] sample; tuser[0] drain
//  m_axis      out        tdata[31:0] updated; tlast last_point
//  cfg         in         we, idx[2:0], wdata[15:0] (sizes in bits 6:0)
//
// One word is taken per cycle while input ready is high; a result reaches the queue through
// the window read and the three arithmetic stages.
// A point is emitted one plane (size_y*size_z words) after its own sample arrives.
// Synchronous active-low reset clears control; window contents are not cleared.
// Input ready falls only when queued plus in-flight results fill the 8-entry queue.
module heat_stencil_3d_euler_top import hse3d_pkg::*; #(
    parameter int MAX_X = 64,
    parameter int MAX_Y = 64,
    parameter int MAX_Z = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [DATA_W-1:0] i_s_axis_tdata,   // [31:0] sample
    input  logic              i_s_axis_tuser,   // [0] drain
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [DATA_W-1:0] o_m_axis_tdata,   // [31:0] updated
    output logic              o_m_axis_tlast,
    input  logic              i_cfg_we,
    input  logic [CIDX_W-1:0] i_cfg_idx,
    input  logic [COEF_W-1:0] i_cfg_wdata
);

    localparam int DEPTH = 2 * MAX_Y * MAX_Z + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int PLW   = $clog2(MAX_Y * MAX_Z + 1);
    localparam int XW    = $clog2(MAX_X + 1);
    localparam int YW    = $clog2(MAX_Y + 1);
    localparam int ZW    = $clog2(MAX_Z + 1);

    logic [SIZE_W-1:0] r_size_x, r_size_y, r_size_z;
    logic [COEF_W-1:0] r_coef_x, r_coef_y, r_coef_z;

    logic [XW-1:0]  sx_c, r_ix, n_ix, r_ox, n_ox;
    logic [YW-1:0]  sy_c, r_iy, n_iy, r_oy, n_oy;
    logic [ZW-1:0]  sz_c, r_iz, n_iz, r_oz, n_oz;
    logic [YW+ZW-1:0] plane_full;
    logic [PLW-1:0] plane, r_pending, n_pending;
    logic [AW-1:0]  r_wr, plane_a, sz_a;
    logic [AW-1:0]  ra0, ra1, rb0, rb1;

    logic acc, is_drain, in_zero, s0_emit, s0_int, s0_last;

    logic              r_v1;
    t_meta             r_meta1;
    logic [DATA_W-1:0] r_xp1;

    logic [DATA_W-1:0] qa0, qa1, qb0, qb1;
    logic              dp_valid, dp_last;
    logic [DATA_W-1:0] dp_updated;
    logic [1:0]        dp_inflight;
    logic [OQ_AW:0]    oq_count;
    logic [OQ_AW+1:0]  busy;

    // Step back from a window slot, wrapping around the circular store.
    function automatic logic [AW-1:0] f_back(input logic [AW-1:0] p, input logic [AW-1:0] o);
        logic [AW:0] d;
        d = {1'b0, p} - {1'b0, o};
        if (d[AW]) begin
            d = d + (AW+1)'(DEPTH);
        end
        return d[AW-1:0];
    endfunction

    // Effective grid sizes
    always_comb begin
        sx_c = (r_size_x < SIZE_W'(3)) ? XW'(3) :
               (32'(r_size_x) > MAX_X) ? XW'(MAX_X) : XW'(r_size_x);
        sy_c = (r_size_y < SIZE_W'(3)) ? YW'(3) :
               (32'(r_size_y) > MAX_Y) ? YW'(MAX_Y) : YW'(r_size_y);
        sz_c = (r_size_z < SIZE_W'(3)) ? ZW'(3) :
               (32'(r_size_z) > MAX_Z) ? ZW'(MAX_Z) : ZW'(r_size_z);
        plane_full = sy_c * sz_c;
        plane      = PLW'(plane_full);
        plane_a    = AW'(plane);
        sz_a       = AW'(sz_c);
    end

    assign acc      = i_s_axis_tvalid && o_s_axis_tready;
    assign is_drain = i_s_axis_tuser;
    assign in_zero  = (r_ix == '0) && (r_iy == '0) && (r_iz == '0);

    // Emission decision and flags of the point that leaves with this word
    always_comb begin
        s0_emit = is_drain ? (in_zero && r_pending != '0) : (r_pending == plane);
        s0_int  = (r_ox != '0) && (r_ox != sx_c - 1'b1) &&
                  (r_oy != '0) && (r_oy != sy_c - 1'b1) &&
                  (r_oz != '0) && (r_oz != sz_c - 1'b1);
        s0_last = (r_ox == sx_c - 1'b1) && (r_oy == sy_c - 1'b1) && (r_oz == sz_c - 1'b1);
        n_pending = r_pending;
        if (!is_drain && !s0_emit) begin
            n_pending = r_pending + 1'b1;
        end else if (is_drain && s0_emit) begin
            n_pending = r_pending - 1'b1;
        end
    end

    // Neighbor addresses; a drain reads the oldest pending sample on port a0.
    always_comb begin
        ra0 = is_drain ? f_back(r_wr, AW'(r_pending)) : f_back(r_wr, plane_a - AW'(1));
        ra1 = f_back(r_wr, plane_a + plane_a);
        rb0 = f_back(r_wr, plane_a - sz_a);
        rb1 = f_back(r_wr, plane_a + sz_a);
    end

    // Raster counters for the incoming and outgoing positions
    always_comb begin
        n_iz = r_iz + 1'b1;
        n_iy = r_iy;
        n_ix = r_ix;
        if (r_iz == sz_c - 1'b1) begin
            n_iz = '0;
            n_iy = r_iy + 1'b1;
            if (r_iy == sy_c - 1'b1) begin
                n_iy = '0;
                n_ix = (r_ix == sx_c - 1'b1) ? '0 : r_ix + 1'b1;
            end
        end
        n_oz = r_oz + 1'b1;
        n_oy = r_oy;
        n_ox = r_ox;
        if (r_oz == sz_c - 1'b1) begin
            n_oz = '0;
            n_oy = r_oy + 1'b1;
            if (r_oy == sy_c - 1'b1) begin
                n_oy = '0;
                n_ox = (r_ox == sx_c - 1'b1) ? '0 : r_ox + 1'b1;
            end
        end
    end

    // Configuration registers and grid control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x  <= SIZE_W'(64);
            r_size_y  <= SIZE_W'(64);
            r_size_z  <= SIZE_W'(64);
            r_coef_x  <= '0;
            r_coef_y  <= '0;
            r_coef_z  <= '0;
            r_ix      <= '0;
            r_iy      <= '0;
            r_iz      <= '0;
            r_ox      <= '0;
            r_oy      <= '0;
            r_oz      <= '0;
            r_pending <= '0;
            r_wr      <= '0;
            r_v1      <= 1'b0;
        end else begin
            r_v1 <= acc;
            if (i_cfg_we && i_cfg_idx < CIDX_W'(6)) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_SIZE_X: r_size_x <= i_cfg_wdata[SIZE_W-1:0];
                    CFG_SIZE_Y: r_size_y <= i_cfg_wdata[SIZE_W-1:0];
                    CFG_SIZE_Z: r_size_z <= i_cfg_wdata[SIZE_W-1:0];
                    CFG_COEF_X: r_coef_x <= i_cfg_wdata;
                    CFG_COEF_Y: r_coef_y <= i_cfg_wdata;
                    CFG_COEF_Z: r_coef_z <= i_cfg_wdata;
                    default: ;
                endcase
                r_ix      <= '0;
                r_iy      <= '0;
                r_iz      <= '0;
                r_ox      <= '0;
                r_oy      <= '0;
                r_oz      <= '0;
                r_pending <= '0;
                r_wr      <= '0;
            end else if (acc) begin
                r_pending <= n_pending;
                if (!is_drain) begin
                    r_ix <= n_ix;
                    r_iy <= n_iy;
                    r_iz <= n_iz;
                    r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
                end
                if (s0_emit) begin
                    r_ox <= n_ox;
                    r_oy <= n_oy;
                    r_oz <= n_oz;
                end
            end
        end
    end

    // Word control that travels alongside the window read
    always_ff @(posedge i_clk) begin
        r_meta1.sample   <= !is_drain;
        r_meta1.emit     <= s0_emit;
        r_meta1.interior <= s0_int;
        r_meta1.last     <= s0_last;
        r_xp1            <= i_s_axis_tdata;
    end

    hse3d_window #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (acc && !is_drain),
        .i_waddr (r_wr),
        .i_wdata (i_s_axis_tdata),
        .i_ra0   (ra0),
        .i_ra1   (ra1),
        .i_rb0   (rb0),
        .i_rb1   (rb1),
        .o_qa0   (qa0),
        .o_qa1   (qa1),
        .o_qb0   (qb0),
        .o_qb1   (qb1)
    );

    hse3d_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_v1       (r_v1),
        .i_meta     (r_meta1),
        .i_xp       (r_xp1),
        .i_qa0      (qa0),
        .i_qa1      (qa1),
        .i_qb0      (qb0),
        .i_qb1      (qb1),
        .i_coef_x   (r_coef_x),
        .i_coef_y   (r_coef_y),
        .i_coef_z   (r_coef_z),
        .o_valid    (dp_valid),
        .o_updated  (dp_updated),
        .o_last     (dp_last),
        .o_inflight (dp_inflight)
    );

    hse3d_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (dp_valid),
        .i_data   (dp_updated),
        .i_last   (dp_last),
        .i_tready (i_m_axis_tready),
        .o_tvalid (o_m_axis_tvalid),
        .o_tdata  (o_m_axis_tdata),
        .o_tlast  (o_m_axis_tlast),
        .o_count  (oq_count)
    );

    // Credit: every word that may still produce a result holds a queue slot.
    assign busy = {1'b0, oq_count} + (OQ_AW+2)'(r_v1 && r_meta1.emit)
                + (OQ_AW+2)'(dp_inflight);
    assign o_s_axis_tready = busy < (OQ_AW+2)'(OQ_DEPTH);

    a_pending_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= plane)
        else $error("pending count exceeds one plane");

    a_queue_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy <= (OQ_AW+2)'(OQ_DEPTH))
        else $error("queued and in-flight results exceed queue depth");

    a_drain_face: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && is_drain && s0_emit) |-> !s0_int)
        else $error("drained point is not on the last plane");

endmodule
